// ===== hw/rtl/external_interrupt_pin_controller_top_assert.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef EXTERNAL_INTERRUPT_PIN_CONTROLLER_TOP_ASSERT_SVH
`define EXTERNAL_INTERRUPT_PIN_CONTROLLER_TOP_ASSERT_SVH

// clocked assertion, quiet while reset is asserted
`define EIPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define EIPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/eipc_pkg.sv =====
// shared types, codes and helpers of the external interrupt pin controller
// no dependencies
package eipc_pkg;

  localparam int unsigned PIN_COUNT_DEF = 8;
  localparam int unsigned PIN_W         = 8;
  localparam int unsigned TRIG_FIELD_W  = 4;
  localparam int unsigned FIRST_W       = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned TDATA_W       = 16;

  // trigger codes of one pin field, the rest are reserved
  typedef enum logic [TRIG_FIELD_W-1:0] {
    TRIG_LOW  = 4'h0,
    TRIG_HIGH = 4'h1,
    TRIG_FALL = 4'h2,
    TRIG_RISE = 4'h3,
    TRIG_BOTH = 4'h4
  } trig_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER = 2'd0,
    CFG_MASK    = 2'd1
  } cfg_idx_e;

  // per pin input of one cell
  typedef struct packed {
    logic level;
    logic clear;
    logic mask;
  } pin_in_t;

  // per pin status handed out of one cell
  typedef struct packed {
    logic pend;
    logic hit;
  } pin_out_t;

  // one result item
  typedef struct packed {
    logic [FIRST_W-1:0] first_pending;
    logic               irq_request;
    logic [PIN_W-1:0]   pending_bits;
  } result_t;

  // trigger condition of one pin
  function automatic logic pin_fires(logic [TRIG_FIELD_W-1:0] code, logic now, logic prev);
    logic fire;
    case (code)
      TRIG_LOW:  fire = !now;
      TRIG_HIGH: fire = now;
      TRIG_FALL: fire = prev && !now;
      TRIG_RISE: fire = !prev && now;
      TRIG_BOTH: fire = prev ^ now;
      default:   fire = 1'b0;
    endcase
    return fire;
  endfunction

endpackage

// ===== hw/rtl/eipc_cell.sv =====
// one pin cell: previous level, pending flag and a link of the priority chain
// depends on eipc_pkg
module eipc_cell
  import eipc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [TRIG_FIELD_W-1:0] code_i,
  input  pin_in_t                 pin_i,
  input  logic                    found_i,
  output logic                    found_o,
  output pin_out_t                pin_o
);

  logic prev_q, prev_d;
  logic pend_q, pend_d;
  logic active;

  // clear first, then set on trigger
  always_comb begin
    pend_d = (pend_q && !pin_i.clear) || pin_fires(code_i, pin_i.level, prev_q);
    prev_d = pin_i.level;
  end

  // priority link: first unmasked pending pin from the low end
  assign active      = pend_d && !pin_i.mask;
  assign found_o     = found_i || active;
  assign pin_o.pend  = pend_d;
  assign pin_o.hit   = active && !found_i;

  // state advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      pend_q <= 1'b0;
    end else if (accept_i) begin
      prev_q <= prev_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== hw/rtl/eipc_skid.sv =====
// two-entry output buffer: main register plus skid register
// depends on eipc_pkg
module eipc_skid
  import eipc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= in_data_i;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_q <= in_data_i;
      end else begin
        main_q <= in_data_i;
      end
    end
  end

endmodule

// ===== hw/rtl/external_interrupt_pin_controller_top.sv =====
// External interrupt pin controller for a group of up to eight pins.
// Input channel s_axis_*: one item per sample tick carries the pin levels
// and a write-one-to-clear mask for the pending flags.
// Output channel m_axis_*: one result item per input item with the pending
// flags, the interrupt request and the lowest unmasked pending pin.
// Configuration: cfg_we_i writes the register cfg_idx_i from cfg_data_i;
// index 0 holds the 4-bit trigger fields, index 1 the mask, others ignored.
// A result is registered in the output buffer when its item is taken.
// Throughput is one item per cycle while the receiver keeps up, set by the
// row of pin cells, which all update in the accepting cycle, and the two-entry output buffer.
// When the receiver stalls, the buffer keeps taking one more item; input
// ready drops only when both output entries are full.
// Reset sets all previous levels high, clears all pending flags, trigger
// fields to low level and masks every pin; the output buffer empties.
// Pins at or above PinCount never become pending and read as zero.
// depends on eipc_pkg, eipc_cell, eipc_skid
module external_interrupt_pin_controller_top
  import eipc_pkg::*;
#(
  parameter int unsigned PinCount = PIN_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // [7:0] pin_levels, [15:8] clear_bits
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata   // [7:0] pending_bits, [8] irq_request,
                                               // [11:9] first_pending, [15:12] zero
);

  localparam int unsigned TrigW = TRIG_FIELD_W * PinCount;

  logic [TrigW-1:0]    trig_q;
  logic [PinCount-1:0] mask_q;
  logic                accept;
  logic [PIN_W-1:0]    levels, clears;
  logic [PinCount:0]   found;
  pin_in_t             pin_in  [PinCount];
  pin_out_t            pin_out [PinCount];
  result_t             res, res_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= '0;
      mask_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER: trig_q <= cfg_data_i[TrigW-1:0];
        CFG_MASK:    mask_q <= cfg_data_i[PinCount-1:0];
        default:     ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign levels = s_axis_tdata[PIN_W-1:0];
  assign clears = s_axis_tdata[2*PIN_W-1:PIN_W];
  assign found[0] = 1'b0;

  // row of pin cells chained by the priority link
  for (genvar g = 0; g < PinCount; g++) begin : g_cell
    assign pin_in[g].level = levels[g];
    assign pin_in[g].clear = clears[g];
    assign pin_in[g].mask  = mask_q[g];

    eipc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .code_i   (trig_q[TRIG_FIELD_W*g +: TRIG_FIELD_W]),
      .pin_i    (pin_in[g]),
      .found_i  (found[g]),
      .found_o  (found[g+1]),
      .pin_o    (pin_out[g])
    );
  end

  // gather the result item; hits are one-hot so indexes can be or-ed
  always_comb begin
    res = '0;
    for (int unsigned i = 0; i < PinCount; i++) begin
      res.pending_bits[i] = pin_out[i].pend;
      if (pin_out[i].hit) begin
        res.first_pending = res.first_pending | FIRST_W'(i);
      end
    end
    res.irq_request = found[PinCount];
  end

  eipc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata = TDATA_W'(res_out);

endmodule

// ===== hw/rtl/eipc_checker.sv =====
// port-level checks of the external interrupt pin controller, bound to the top
// depends on eipc_pkg and external_interrupt_pin_controller_top_assert.svh
`include "external_interrupt_pin_controller_top_assert.svh"

module eipc_checker
  import eipc_pkg::*;
#(
  parameter int unsigned PinCount = PIN_COUNT_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  logic [PIN_W-1:0]   unused_pins;
  logic [PIN_W-1:0]   pend_bits;
  logic [FIRST_W-1:0] first_idx;
  logic               irq_bit;
  logic               stalled;
  logic               first_ok;

  assign unused_pins = 8'hff << PinCount;
  assign pend_bits   = m_axis_tdata[PIN_W-1:0];
  assign irq_bit     = m_axis_tdata[PIN_W];
  assign first_idx   = m_axis_tdata[PIN_W+FIRST_W:PIN_W+1];
  assign stalled     = m_axis_tvalid && !m_axis_tready;
  assign first_ok    = irq_bit ? pend_bits[first_idx] : (first_idx == '0);

  // a stalled result holds
  `EIPC_ASSERT(a_hold, stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")

  // an empty output side always takes an item
  `EIPC_ASSERT_ALWAYS(a_ready, !m_axis_tvalid |-> s_axis_tready, "not ready while output empty")

  // without a request the index reads zero, with one it names a pending pin
  `EIPC_ASSERT(a_first, m_axis_tvalid |-> first_ok, "first_pending inconsistent")

  // pins beyond the group never show pending
  `EIPC_ASSERT(a_unused, m_axis_tvalid |-> ((pend_bits & unused_pins) == 8'h00), "unused pin pending")

endmodule

bind external_interrupt_pin_controller_top eipc_checker #(.PinCount(PinCount)) u_eipc_checker (.*);
